/* hdl/hpba_pkg.sv */
package hpba_pkg;

  localparam int ZONES_DEF         = 6;
  localparam int STALE_LIMIT_DEF   = 10000;
  localparam int UPDATE_PERIOD_DEF = 1000;

  localparam int NUM_CUR    = 6;
  localparam int TEMP_W     = 16;
  localparam int AGE_W      = 14;
  localparam int CNT_W      = 10;
  localparam int CUR_W      = 12;
  localparam int BUDGET_W   = 15;
  localparam int MASK_W     = 6;
  localparam int ZONE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [TEMP_W-1:0] TEMP_RESET = 16'sd256;
  localparam logic signed [TEMP_W:0]   ONE_DEGREE = 17'sd256;
  localparam logic signed [TEMP_W:0]   TEMP_MAX   = 17'sd32767;
  localparam logic [BUDGET_W-1:0]      BUDGET_RESET = 15'd1;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ZONE0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE5     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd7;

  typedef struct packed {
    logic report;
    logic tick;
    logic stale;
    logic scan;
    logic pick;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic due;
    logic scan_last;
    logic pass_last;
  } dp_status_t;

endpackage

/* hdl/hpba_datapath.sv */
module hpba_datapath
  import hpba_pkg::*;
#(
  parameter int ZONES         = ZONES_DEF,
  parameter int STALE_LIMIT   = STALE_LIMIT_DEF,
  parameter int UPDATE_PERIOD = UPDATE_PERIOD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic [ZONE_W-1:0]           in_zone,
  input  logic signed [TEMP_W-1:0]    in_reading,
  input  logic                        in_finite,
  output logic [MASK_W-1:0]           out_mask,
  output logic [BUDGET_W-1:0]         out_total
);

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

  logic [CUR_W-1:0]           cur_r [NUM_CUR];
  logic [BUDGET_W-1:0]        budget_r;
  logic signed [TEMP_W-1:0]   thr_r;
  logic                       changed_r;

  logic signed [TEMP_W-1:0]   temp_r [ZONES];
  logic [AGE_W-1:0]           age_r [ZONES];
  logic [CNT_W-1:0]           cnt_r;

  logic [ZW-1:0]              k_r;
  logic [ZW-1:0]              pass_r;
  logic [ZW-1:0]              best_r;
  logic signed [TEMP_W-1:0]   best_temp_r;
  logic                       best_valid_r;
  logic [ZONES-1:0]           done_r;
  logic [MASK_W-1:0]          mask_r;
  logic [BUDGET_W-1:0]        total_r;
  logic [MASK_W-1:0]          out_mask_r;
  logic [BUDGET_W-1:0]        out_total_r;

  logic [CNT_W-1:0]           cnt_inc;
  logic signed [TEMP_W:0]     warm_sum;
  logic signed [TEMP_W-1:0]   warm;
  logic                       take;
  logic [ZONE_W:0]            best_ext;
  logic [CUR_W-1:0]           best_cur;
  logic [BUDGET_W:0]          sum;
  logic                       grant;

  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign warm_sum = {thr_r[TEMP_W-1], thr_r} + ONE_DEGREE;
  assign warm     = (warm_sum > TEMP_MAX) ? TEMP_MAX[TEMP_W-1:0] : warm_sum[TEMP_W-1:0];
  assign take     = !done_r[k_r] && (!best_valid_r || temp_r[k_r] < best_temp_r);
  assign best_ext = (ZONE_W + 1)'(best_r);
  assign best_cur = (best_ext < (ZONE_W + 1)'(NUM_CUR)) ? cur_r[best_ext[ZONE_W-1:0]] : '0;
  assign sum      = {1'b0, total_r} + (BUDGET_W + 1)'(best_cur);
  assign grant    = (best_temp_r < thr_r) && (sum < {1'b0, budget_r});

  assign status.due       = (cnt_inc >= CNT_W'(UPDATE_PERIOD)) || changed_r;
  assign status.scan_last = (k_r == ZW'(ZONES - 1));
  assign status.pass_last = (pass_r == ZW'(ZONES - 1));

  assign out_mask  = out_mask_r;
  assign out_total = out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CUR; i++) begin
        cur_r[i] <= '0;
      end
      budget_r  <= BUDGET_RESET;
      thr_r     <= '0;
      changed_r <= 1'b0;
      cnt_r     <= '0;
      for (int i = 0; i < ZONES; i++) begin
        temp_r[i] <= TEMP_RESET;
        age_r[i]  <= '0;
      end
      out_mask_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index inside {[REG_ZONE0:REG_ZONE5]}) begin
          cur_r[cfg_index] <= cfg_data[CUR_W-1:0];
          changed_r        <= 1'b1;
        end else if (cfg_index == REG_BUDGET) begin
          budget_r  <= cfg_data[BUDGET_W-1:0];
          changed_r <= 1'b1;
        end else if (cfg_index == REG_THRESHOLD) begin
          thr_r <= cfg_data;
        end
      end
      if (cmd.tick) begin
        cnt_r <= status.due ? '0 : cnt_inc;
        if (status.due) begin
          changed_r <= 1'b0;
        end
      end
      for (int i = 0; i < ZONES; i++) begin
        if (cmd.report && in_finite && in_zone == ZONE_W'(i)) begin
          temp_r[i] <= in_reading;
          age_r[i]  <= '0;
        end
        if (cmd.tick && age_r[i] != '1) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
        if (cmd.stale && age_r[i] > AGE_W'(STALE_LIMIT)) begin
          temp_r[i] <= warm;
        end
      end
      if (cmd.load) begin
        out_mask_r <= mask_r;
      end
    end
  end

  // selection pass: coldest remaining zone, lower index wins ties
  always_ff @(posedge clk) begin
    if (cmd.stale) begin
      k_r          <= '0;
      pass_r       <= '0;
      best_valid_r <= 1'b0;
      done_r       <= '0;
      mask_r       <= '0;
      total_r      <= '0;
    end
    if (cmd.scan) begin
      k_r <= status.scan_last ? '0 : k_r + 1'b1;
      if (take) begin
        best_r       <= k_r;
        best_temp_r  <= temp_r[k_r];
        best_valid_r <= 1'b1;
      end
    end
    if (cmd.pick) begin
      for (int i = 0; i < ZONES; i++) begin
        if (best_r == ZW'(i)) begin
          done_r[i] <= 1'b1;
        end
      end
      if (grant) begin
        total_r <= sum[BUDGET_W-1:0];
        if (best_ext < (ZONE_W + 1)'(MASK_W)) begin
          mask_r[best_ext[ZONE_W-1:0]] <= 1'b1;
        end
      end
      pass_r       <= pass_r + 1'b1;
      best_valid_r <= 1'b0;
    end
    if (cmd.load) begin
      out_total_r <= total_r;
    end
  end

endmodule

/* hdl/hpba_ctrl.sv */
module hpba_ctrl
  import hpba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_op,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STALE,
    S_SCAN,
    S_PICK,
    S_OUT
  } state_t;

  state_t state_r;
  logic   out_tvalid_r;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd        = '0;
    cmd.report = accept && in_op == OP_REPORT;
    cmd.tick   = accept && in_op == OP_TICK;
    cmd.stale  = (state_r == S_STALE);
    cmd.scan   = (state_r == S_SCAN);
    cmd.pick   = (state_r == S_PICK);
    cmd.load   = (state_r == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.tick && status.due) begin
            state_r <= S_STALE;
          end
        end
        S_STALE: state_r <= S_SCAN;
        S_SCAN: begin
          if (status.scan_last) begin
            state_r <= S_PICK;
          end
        end
        S_PICK:  state_r <= status.pass_last ? S_OUT : S_SCAN;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/heater_power_budget_allocator_core.sv */
// Heater power budget allocator. Keeps the last temperature and reading age
// of each heater zone. A report word (tuser 0) stores a finite reading and
// leaves the input ready. A tick word (tuser 1) ages all readings; every
// UPDATE_PERIOD ticks, or on the first tick after a current or budget write,
// it runs an evaluation that replaces stale readings, walks the zones
// coldest first and switches on each cold zone whose current keeps the summed
// current strictly below the budget. The evaluation is one shared compare
// unit scanning the zone registers: after the stale step it runs ZONES
// selection passes of ZONES compares each, then loads the result word;
// no input is taken meanwhile. The result register lets the next word in
// while a result is pending.
module heater_power_budget_allocator_core
  import hpba_pkg::*;
#(
  parameter int ZONES         = ZONES_DEF,
  parameter int STALE_LIMIT   = STALE_LIMIT_DEF,
  parameter int UPDATE_PERIOD = UPDATE_PERIOD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // zone, reading, reading_finite
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // heater_mask, total_current
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [MASK_W-1:0]   mask;
  logic [BUDGET_W-1:0] total;

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_DATA_W - BUDGET_W - MASK_W)'(0), total, mask};

  hpba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  hpba_datapath #(
    .ZONES         (ZONES),
    .STALE_LIMIT   (STALE_LIMIT),
    .UPDATE_PERIOD (UPDATE_PERIOD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_zone    (in_tdata[ZONE_W-1:0]),
    .in_reading (in_tdata[ZONE_W+TEMP_W-1:ZONE_W]),
    .in_finite  (in_tdata[ZONE_W+TEMP_W]),
    .out_mask   (mask),
    .out_total  (total)
  );

endmodule

/* hdl/hpba_checker.sv */
module hpba_checker
  import hpba_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_report_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_REPORT |=> in_tready)
    else $error("report word blocked the input");

  a_report_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_REPORT && !out_tvalid |=> !out_tvalid)
    else $error("report word produced a result");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without an evaluation");

endmodule

bind heater_power_budget_allocator_core hpba_checker u_hpba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
